### hdl/brl_pkg.sv
package brl_pkg;

    // Coordinate and derived widths
    localparam int COORD_BITS = 14;
    localparam int DELTA_BITS = COORD_BITS + 1;
    localparam int ERR_BITS   = COORD_BITS + 2;

    // Clip register
    localparam int CLIP_BITS = 13;
    localparam logic [CLIP_BITS-1:0] CLIP_RESET = CLIP_BITS'(800);
    localparam int CMP_BITS = ((COORD_BITS > CLIP_BITS) ? COORD_BITS : CLIP_BITS) + 1;

    // Configuration port
    localparam int ADDR_BITS = 3;
    localparam int DATA_BITS = 32;
    localparam logic REG_CLIP_LIMIT = 1'b0;

    // Command queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } op_t;

    // Classified transaction handed from front to back
    typedef struct packed {
        op_t                           op;
        logic                          steep;
        logic                          minor_down;
        logic signed [COORD_BITS-1:0]  major_pos;
        logic signed [COORD_BITS-1:0]  minor_pos;
        logic signed [COORD_BITS-1:0]  major_end;
        logic signed [ERR_BITS-1:0]    error_term;
        logic [DELTA_BITS-1:0]         delta_major;
        logic [DELTA_BITS-1:0]         delta_minor;
    } line_cmd_t;

endpackage

### hdl/bresenham_line_rasterizer_core.sv
// A step transaction passes through the front register, the queue and the back result register
// in that order, and can wait at each one while the stage after it is full.
// Throughput: one transaction per cycle unless out_ready holds the output; the back walks one
// pixel per cycle with a single add and compare on the error term.
// Reset (rst_n, asynchronous, active low): no line active, queue empty, clip limit 800.
module bresenham_line_rasterizer_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [brl_pkg::ADDR_BITS-1:0]         paddr,
    input  logic [brl_pkg::DATA_BITS-1:0]         pwdata,
    output logic [brl_pkg::DATA_BITS-1:0]         prdata,
    output logic                                  pready,
    // Input channel
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  op,
    input  logic signed [brl_pkg::COORD_BITS-1:0] x_start,
    input  logic signed [brl_pkg::COORD_BITS-1:0] y_start,
    input  logic signed [brl_pkg::COORD_BITS-1:0] x_end,
    input  logic signed [brl_pkg::COORD_BITS-1:0] y_end,
    // Output channel
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [brl_pkg::COORD_BITS-1:0] pixel_x,
    output logic signed [brl_pkg::COORD_BITS-1:0] pixel_y,
    output logic                                  inside_res,
    output logic                                  last,
    output logic                                  no_pixel
);
    import brl_pkg::*;

    logic [CLIP_BITS-1:0] clip_limit_reg;
    logic                 cfg_write;
    logic                 q_push;
    logic                 q_full;
    logic                 q_valid;
    logic                 q_pop;
    line_cmd_t            push_cmd;
    line_cmd_t            pop_cmd;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // Clip limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_limit_reg <= CLIP_RESET;
        end
        else if (cfg_write && paddr[2] == REG_CLIP_LIMIT)
        begin
            clip_limit_reg <= pwdata[CLIP_BITS-1:0];
        end
    end

    // Read back on aligned addresses
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_CLIP_LIMIT && paddr[1:0] == 2'b00)
        begin
            prdata = DATA_BITS'(clip_limit_reg);
        end
    end

    brl_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .op       (op),
        .x_start  (x_start),
        .y_start  (y_start),
        .x_end    (x_end),
        .y_end    (y_end),
        .q_push   (q_push),
        .q_cmd    (push_cmd),
        .q_full   (q_full)
    );

    brl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .valid    (q_valid),
        .pop_cmd  (pop_cmd),
        .pop      (q_pop)
    );

    brl_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_cmd      (pop_cmd),
        .q_pop      (q_pop),
        .clip_limit (clip_limit_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .inside_res (inside_res),
        .last       (last),
        .no_pixel   (no_pixel)
    );

endmodule

### hdl/brl_front.sv
module brl_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  op,
    input  logic signed [brl_pkg::COORD_BITS-1:0] x_start,
    input  logic signed [brl_pkg::COORD_BITS-1:0] y_start,
    input  logic signed [brl_pkg::COORD_BITS-1:0] x_end,
    input  logic signed [brl_pkg::COORD_BITS-1:0] y_end,
    output logic                                  q_push,
    output brl_pkg::line_cmd_t                    q_cmd,
    input  logic                                  q_full
);
    import brl_pkg::*;

    logic                          f_valid_reg;
    op_t                           f_op_reg;
    logic signed [COORD_BITS-1:0]  f_x1_reg;
    logic signed [COORD_BITS-1:0]  f_y1_reg;
    logic signed [COORD_BITS-1:0]  f_x2_reg;
    logic signed [COORD_BITS-1:0]  f_y2_reg;
    logic [DELTA_BITS-1:0]         f_dx_reg;
    logic signed [DELTA_BITS-1:0]  f_dy_reg;

    logic signed [DELTA_BITS-1:0]  dx_raw;
    logic signed [DELTA_BITS-1:0]  dy_raw;
    logic                          swap;
    logic [DELTA_BITS-1:0]         dx_abs;
    logic signed [DELTA_BITS-1:0]  dy_ord;

    logic                          down;
    logic [DELTA_BITS-1:0]         ady;
    logic                          x_major;
    logic [DELTA_BITS-1:0]         d_major;
    logic [DELTA_BITS-1:0]         d_minor;
    logic                          accept;

    assign in_ready = !f_valid_reg || !q_full;
    assign accept   = in_valid && in_ready;
    assign q_push   = f_valid_reg && !q_full;

    // Order endpoints by x and take raw deltas
    always_comb
    begin
        dx_raw = {x_end[COORD_BITS-1], x_end} - {x_start[COORD_BITS-1], x_start};
        dy_raw = {y_end[COORD_BITS-1], y_end} - {y_start[COORD_BITS-1], y_start};
        swap   = dx_raw[DELTA_BITS-1];
        dx_abs = swap ? DELTA_BITS'(-dx_raw) : DELTA_BITS'(dx_raw);
        dy_ord = swap ? -dy_raw : dy_raw;
    end

    // Hold the ordered transaction until the queue takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            f_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f_op_reg <= op_t'(op);
            f_x1_reg <= swap ? x_end : x_start;
            f_y1_reg <= swap ? y_end : y_start;
            f_x2_reg <= swap ? x_start : x_end;
            f_y2_reg <= swap ? y_start : y_end;
            f_dx_reg <= dx_abs;
            f_dy_reg <= dy_ord;
        end
    end

    // Pick major axis, minor direction and initial error
    always_comb
    begin
        down    = f_dy_reg[DELTA_BITS-1];
        ady     = down ? DELTA_BITS'(-f_dy_reg) : DELTA_BITS'(f_dy_reg);
        x_major = f_dx_reg > ady;
        q_cmd.op         = f_op_reg;
        q_cmd.minor_down = down;
        q_cmd.steep      = !x_major;
        if (x_major)
        begin
            q_cmd.major_pos = f_x1_reg;
            q_cmd.major_end = f_x2_reg;
            q_cmd.minor_pos = f_y1_reg;
            d_major         = f_dx_reg;
            d_minor         = ady;
        end
        else if (down)
        begin
            q_cmd.major_pos = f_y2_reg;
            q_cmd.major_end = f_y1_reg;
            q_cmd.minor_pos = f_x2_reg;
            d_major         = ady;
            d_minor         = f_dx_reg;
        end
        else
        begin
            q_cmd.major_pos = f_y1_reg;
            q_cmd.major_end = f_y2_reg;
            q_cmd.minor_pos = f_x1_reg;
            d_major         = ady;
            d_minor         = f_dx_reg;
        end
        q_cmd.delta_major = d_major;
        q_cmd.delta_minor = d_minor;
        q_cmd.error_term  = $signed(ERR_BITS'(d_minor) - ERR_BITS'(d_major));
    end

endmodule

### hdl/brl_queue.sv
module brl_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  brl_pkg::line_cmd_t push_cmd,
    output logic               full,
    output logic               valid,
    output brl_pkg::line_cmd_t pop_cmd,
    input  logic               pop
);
    import brl_pkg::*;

    line_cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg;
    logic [QPTR_BITS-1:0]   rd_ptr_reg;
    logic [QCNT_BITS-1:0]   count_reg;
    logic [QPTR_BITS-1:0]   wr_ptr_next;
    logic [QPTR_BITS-1:0]   rd_ptr_next;
    logic [QCNT_BITS-1:0]   count_next;

    assign full    = count_reg == QCNT_BITS'(QUEUE_DEPTH);
    assign valid   = count_reg != '0;
    assign pop_cmd = mem_reg[rd_ptr_reg];

    // Advance pointers with wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid)
        else $error("queue pop while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_BITS'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

### hdl/brl_back.sv
module brl_back (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  q_valid,
    input  brl_pkg::line_cmd_t                    q_cmd,
    output logic                                  q_pop,
    input  logic [brl_pkg::CLIP_BITS-1:0]         clip_limit,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [brl_pkg::COORD_BITS-1:0] pixel_x,
    output logic signed [brl_pkg::COORD_BITS-1:0] pixel_y,
    output logic                                  inside_res,
    output logic                                  last,
    output logic                                  no_pixel
);
    import brl_pkg::*;

    // Line walk state
    logic signed [COORD_BITS-1:0]  major_pos_reg;
    logic signed [COORD_BITS-1:0]  minor_pos_reg;
    logic signed [COORD_BITS-1:0]  major_end_reg;
    logic signed [ERR_BITS-1:0]    error_term_reg;
    logic [DELTA_BITS-1:0]         delta_major_reg;
    logic [DELTA_BITS-1:0]         delta_minor_reg;
    logic                          minor_down_reg;
    logic                          steep_reg;
    logic                          active_reg;

    // Result register
    logic                          out_valid_reg;
    logic signed [COORD_BITS-1:0]  pixel_x_reg;
    logic signed [COORD_BITS-1:0]  pixel_y_reg;
    logic                          inside_reg;
    logic                          last_reg;
    logic                          no_pixel_reg;

    logic                          out_free;
    logic                          is_start;
    logic                          step_fire;
    logic signed [COORD_BITS-1:0]  px;
    logic signed [COORD_BITS-1:0]  py;
    logic signed [DELTA_BITS-1:0]  major_inc;
    logic                          at_last;
    logic                          px_in;
    logic                          py_in;
    logic                          err_ge0;
    logic signed [ERR_BITS-1:0]    err_adj;
    logic signed [ERR_BITS-1:0]    error_term_next;
    logic signed [COORD_BITS-1:0]  minor_pos_next;

    assign out_free  = !out_valid_reg || out_ready;
    assign is_start  = q_cmd.op == OP_START;
    assign q_pop     = q_valid && (is_start || out_free);
    assign step_fire = q_pop && !is_start;

    // Current pixel, clip test and end test
    always_comb
    begin
        px        = steep_reg ? minor_pos_reg : major_pos_reg;
        py        = steep_reg ? major_pos_reg : minor_pos_reg;
        px_in     = !px[COORD_BITS-1] && (CMP_BITS'(px) < CMP_BITS'(clip_limit));
        py_in     = !py[COORD_BITS-1] && (CMP_BITS'(py) < CMP_BITS'(clip_limit));
        major_inc = {major_pos_reg[COORD_BITS-1], major_pos_reg} + 1'b1;
        at_last   = major_inc >= $signed({major_end_reg[COORD_BITS-1], major_end_reg});
    end

    // Error update and minor step
    always_comb
    begin
        err_ge0 = !error_term_reg[ERR_BITS-1];
        err_adj = err_ge0 ? $signed(ERR_BITS'(delta_minor_reg) - ERR_BITS'(delta_major_reg))
                          : $signed(ERR_BITS'(delta_minor_reg));
        error_term_next = error_term_reg + err_adj;
        if (!err_ge0)
        begin
            minor_pos_next = minor_pos_reg;
        end
        else if (minor_down_reg)
        begin
            minor_pos_next = minor_pos_reg - 1'b1;
        end
        else
        begin
            minor_pos_next = minor_pos_reg + 1'b1;
        end
    end

    // Load a new line or advance the walk
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            major_pos_reg   <= '0;
            minor_pos_reg   <= '0;
            major_end_reg   <= '0;
            error_term_reg  <= '0;
            delta_major_reg <= '0;
            delta_minor_reg <= '0;
            minor_down_reg  <= 1'b0;
            steep_reg       <= 1'b0;
            active_reg      <= 1'b0;
        end
        else if (q_pop && is_start)
        begin
            major_pos_reg   <= q_cmd.major_pos;
            minor_pos_reg   <= q_cmd.minor_pos;
            major_end_reg   <= q_cmd.major_end;
            error_term_reg  <= q_cmd.error_term;
            delta_major_reg <= q_cmd.delta_major;
            delta_minor_reg <= q_cmd.delta_minor;
            minor_down_reg  <= q_cmd.minor_down;
            steep_reg       <= q_cmd.steep;
            active_reg      <= q_cmd.delta_major != '0;
        end
        else if (step_fire && active_reg)
        begin
            major_pos_reg  <= COORD_BITS'(major_inc);
            minor_pos_reg  <= minor_pos_next;
            error_term_reg <= error_term_next;
            active_reg     <= !at_last;
        end
    end

    // Output register: fill on a step, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_fire)
        begin
            if (active_reg)
            begin
                pixel_x_reg  <= px;
                pixel_y_reg  <= py;
                inside_reg   <= px_in && py_in;
                last_reg     <= at_last;
                no_pixel_reg <= 1'b0;
            end
            else
            begin
                pixel_x_reg  <= '0;
                pixel_y_reg  <= '0;
                inside_reg   <= 1'b0;
                last_reg     <= 1'b0;
                no_pixel_reg <= 1'b1;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_x    = pixel_x_reg;
    assign pixel_y    = pixel_y_reg;
    assign inside_res = inside_reg;
    assign last       = last_reg;
    assign no_pixel   = no_pixel_reg;

    a_active_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (major_pos_reg < major_end_reg))
        else $error("active walk past its end");

    a_error_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> ((error_term_reg >= -$signed(ERR_BITS'(delta_major_reg)))
                     && (error_term_reg < $signed(ERR_BITS'(delta_minor_reg)))))
        else $error("error term out of bounds");

    a_no_pixel_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && no_pixel_reg) |-> (pixel_x_reg == '0 && pixel_y_reg == '0
                                            && !inside_reg && !last_reg))
        else $error("no-pixel result carries data");

    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        (step_fire && active_reg && at_last) |=> !active_reg)
        else $error("line still active after last pixel");

endmodule

### tb/tb_bresenham_line_rasterizer_core.sv
`timescale 1ns / 1ps

module tb_bresenham_line_rasterizer_core;

    import brl_pkg::*;

    localparam int COORD_MAX    = (1 << (COORD_BITS - 1)) - 1;
    localparam int COORD_MIN    = -(1 << (COORD_BITS - 1));
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;
    localparam logic [ADDR_BITS-1:0] CLIP_ADDR = ADDR_BITS'(4 * int'(REG_CLIP_LIMIT));

    typedef struct packed {
        op_t                          op;
        logic signed [COORD_BITS-1:0] xs;
        logic signed [COORD_BITS-1:0] ys;
        logic signed [COORD_BITS-1:0] xe;
        logic signed [COORD_BITS-1:0] ye;
    } line_item_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
        logic                         in_clip;
        logic                         final_px;
        logic                         no_pix;
    } pixel_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [ADDR_BITS-1:0]         paddr = '0;
    logic [DATA_BITS-1:0]         pwdata = '0;
    logic [DATA_BITS-1:0]         prdata;
    logic                         pready;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic                         op = 1'b0;
    logic signed [COORD_BITS-1:0] x_start = '0;
    logic signed [COORD_BITS-1:0] y_start = '0;
    logic signed [COORD_BITS-1:0] x_end = '0;
    logic signed [COORD_BITS-1:0] y_end = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic                         inside_res;
    logic                         last;
    logic                         no_pixel;

    // Pending line commands and predicted pixels
    line_item_t line_q[$];
    pixel_t     pixel_q[$];
    pixel_t     seen_pixel;
    pixel_t     want_pixel;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int bad_count = 0;

    // Walker state mirrored at the block's widths
    logic signed [COORD_BITS-1:0] walk_major = '0;
    logic signed [COORD_BITS-1:0] walk_minor = '0;
    logic signed [COORD_BITS-1:0] walk_stop = '0;
    logic signed [ERR_BITS-1:0]   walk_err = '0;
    logic [DELTA_BITS-1:0]        walk_dmaj = '0;
    logic [DELTA_BITS-1:0]        walk_dmin = '0;
    logic                         walk_down = 1'b0;
    logic                         walk_steep = 1'b0;
    logic                         walk_active = 1'b0;
    logic [CLIP_BITS-1:0]         clip_reg = CLIP_RESET;

    int clip_plan[6] = '{4096, 1, 0, 8191, 37, -1};

    bresenham_line_rasterizer_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .x_start    (x_start),
        .y_start    (y_start),
        .x_end      (x_end),
        .y_end      (y_end),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .inside_res (inside_res),
        .last       (last),
        .no_pixel   (no_pixel)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Load or advance the line walk for one accepted transaction, queue a pixel for each step
    task automatic trace_item(input line_item_t it);
        int     x1, y1, x2, y2, t, dx, dy;
        int     maj, mn, stop, err, dmaj, dmin, px, py, lim;
        pixel_t p;
        if (it.op == OP_START)
        begin
            x1 = $signed(it.xs);
            y1 = $signed(it.ys);
            x2 = $signed(it.xe);
            y2 = $signed(it.ye);
            // order by x
            if (x2 < x1)
            begin
                t = x1; x1 = x2; x2 = t;
                t = y1; y1 = y2; y2 = t;
            end
            dx = x2 - x1;
            dy = y2 - y1;
            walk_down = 1'b0;
            if (dy < 0)
            begin
                walk_down = 1'b1;
                dy = -dy;
                // steep falling lines walk from the lower end in y
                if (dy >= dx)
                begin
                    t = x1; x1 = x2; x2 = t;
                    t = y1; y1 = y2; y2 = t;
                end
            end
            if (dx > dy)
            begin
                walk_steep = 1'b0;
                maj  = x1;
                stop = x2;
                mn   = y1;
                dmaj = dx;
                dmin = dy;
            end
            else
            begin
                walk_steep = 1'b1;
                maj  = y1;
                stop = y2;
                mn   = x1;
                dmaj = y2 - y1;
                dmin = (x2 >= x1) ? (x2 - x1) : (x1 - x2);
            end
            walk_major  = maj[COORD_BITS-1:0];
            walk_stop   = stop[COORD_BITS-1:0];
            walk_minor  = mn[COORD_BITS-1:0];
            walk_dmaj   = dmaj[DELTA_BITS-1:0];
            walk_dmin   = dmin[DELTA_BITS-1:0];
            err         = dmin - dmaj;
            walk_err    = err[ERR_BITS-1:0];
            walk_active = (stop > maj);
        end
        else if (!walk_active)
        begin
            p = '0;
            p.no_pix = 1'b1;
            pixel_q.insert(pixel_q.size(), p);
        end
        else
        begin
            maj  = walk_major;
            mn   = walk_minor;
            stop = walk_stop;
            err  = walk_err;
            dmaj = walk_dmaj;
            dmin = walk_dmin;
            lim  = clip_reg;
            px   = walk_steep ? mn : maj;
            py   = walk_steep ? maj : mn;
            p.px       = px[COORD_BITS-1:0];
            p.py       = py[COORD_BITS-1:0];
            p.in_clip  = (px >= 0 && px < lim && py >= 0 && py < lim);
            p.final_px = (maj + 1 >= stop);
            p.no_pix   = 1'b0;
            pixel_q.insert(pixel_q.size(), p);
            // step the minor axis when the error goes non-negative
            if (err >= 0)
            begin
                mn  = walk_down ? mn - 1 : mn + 1;
                err = err - dmaj;
            end
            err = err + dmin;
            maj = maj + 1;
            walk_major = maj[COORD_BITS-1:0];
            walk_minor = mn[COORD_BITS-1:0];
            walk_err   = err[ERR_BITS-1:0];
            if (maj >= stop)
                walk_active = 1'b0;
        end
    endtask

    // Drive input transactions from the pending queue
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
                trace_item(line_q.pop_front());
            if (line_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                op       <= line_q[0].op;
                x_start  <= line_q[0].xs;
                y_start  <= line_q[0].ys;
                x_end    <= line_q[0].xe;
                y_end    <= line_q[0].ye;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Check each result transaction against the oldest predicted pixel
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                seen_pixel = '{pixel_x, pixel_y, inside_res, last, no_pixel};
                if (pixel_q.size() == 0)
                begin
                    bad_count++;
                    if (bad_count <= MAX_REPORTS)
                        $display("unexpected pixel x=%0d y=%0d in=%0b last=%0b none=%0b",
                                 seen_pixel.px, seen_pixel.py, seen_pixel.in_clip,
                                 seen_pixel.final_px, seen_pixel.no_pix);
                end
                else
                begin
                    want_pixel = pixel_q.pop_front();
                    if (seen_pixel.px !== want_pixel.px || seen_pixel.py !== want_pixel.py ||
                        seen_pixel.in_clip !== want_pixel.in_clip ||
                        seen_pixel.final_px !== want_pixel.final_px ||
                        seen_pixel.no_pix !== want_pixel.no_pix)
                    begin
                        bad_count++;
                        if (bad_count <= MAX_REPORTS)
                            $display({"pixel mismatch: expected x=%0d y=%0d in=%0b last=%0b ",
                                      "none=%0b, got x=%0d y=%0d in=%0b last=%0b none=%0b"},
                                     want_pixel.px, want_pixel.py, want_pixel.in_clip,
                                     want_pixel.final_px, want_pixel.no_pix,
                                     seen_pixel.px, seen_pixel.py, seen_pixel.in_clip,
                                     seen_pixel.final_px, seen_pixel.no_pix);
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic void push_line(input int xs, input int ys, input int xe, input int ye);
        line_item_t it;
        it.op = OP_START;
        it.xs = xs[COORD_BITS-1:0];
        it.ys = ys[COORD_BITS-1:0];
        it.xe = xe[COORD_BITS-1:0];
        it.ye = ye[COORD_BITS-1:0];
        line_q.insert(line_q.size(), it);
    endfunction

    // Step transactions carry random coordinates, which the block ignores
    function automatic void push_step(input int n);
        line_item_t it;
        for (int i = 0; i < n; i++)
        begin
            it.op = OP_STEP;
            it.xs = COORD_BITS'($urandom);
            it.ys = COORD_BITS'($urandom);
            it.xe = COORD_BITS'($urandom);
            it.ye = COORD_BITS'($urandom);
            line_q.insert(line_q.size(), it);
        end
    endfunction

    // Pick a coordinate anywhere, near zero, near the clip edge, or on the canvas
    function automatic int pick_coord();
        int v;
        case ($urandom_range(3))
            0:       v = int'($urandom_range(COORD_MAX - COORD_MIN)) + COORD_MIN;
            1:       v = int'($urandom_range(40)) - 20;
            2:       v = int'(clip_reg) + int'($urandom_range(40)) - 20;
            default: v = $urandom_range(clip_reg);
        endcase
        if (v > COORD_MAX)
            v = COORD_MAX;
        if (v < COORD_MIN)
            v = COORD_MIN;
        return v;
    endfunction

    // Offset by up to span, reflecting back into range
    function automatic int offset_coord(input int base, input int span);
        int d, v;
        d = int'($urandom_range(2 * span)) - span;
        v = base + d;
        if (v > COORD_MAX || v < COORD_MIN)
            v = base - d;
        return v;
    endfunction

    // Queue mostly whole lines, plus cut-short lines and lone steps
    task automatic queue_random_lines(input int n_items);
        int count, kind, span, xs, ys, xe, ye, len, steps;
        count = 0;
        while (count < n_items)
        begin
            kind = $urandom_range(99);
            if (kind < 8)
            begin
                push_step(1);
                count++;
            end
            else
            begin
                if (kind < 13)
                    span = COORD_MAX;
                else
                    span = ($urandom_range(3) == 0) ? 40 : 10;
                xs = pick_coord();
                ys = pick_coord();
                xe = offset_coord(xs, span);
                ye = offset_coord(ys, span);
                push_line(xs, ys, xe, ye);
                len = (xe > xs) ? xe - xs : xs - xe;
                if (((ye > ys) ? ye - ys : ys - ye) > len)
                    len = (ye > ys) ? ye - ys : ys - ye;
                if (span == COORD_MAX || $urandom_range(9) == 0)
                    steps = $urandom_range(6);
                else
                    steps = len + int'($urandom_range(2));
                push_step(steps);
                count += 1 + steps;
            end
        end
    endtask

    // Hold until every queued transaction is in and every pixel is out
    task automatic wait_idle();
        while (line_q.size() != 0 || in_valid || pixel_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic read_clip();
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= CLIP_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== DATA_BITS'(clip_reg))
        begin
            bad_count++;
            if (bad_count <= MAX_REPORTS)
                $display("clip_limit readback mismatch: expected %0d, got %0d",
                         clip_reg, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write clip_limit with junk in the unused upper bits, then read it back
    task automatic program_clip(input int value);
        logic [DATA_BITS-1:0] data;
        data = $urandom;
        data[CLIP_BITS-1:0] = value[CLIP_BITS-1:0];
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CLIP_ADDR;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        clip_reg = value[CLIP_BITS-1:0];
        read_clip();
    endtask

    // Stimulus: directed lines at the reset clip, then random phases
    initial
    begin
        int value;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        read_clip();

        send_idle_pct = 20;
        recv_idle_pct = 77;
        // step with no line yet
        push_step(1);
        // shallow rising line, replaced mid-walk by a slope of minus one
        push_line(0, 0, 4, 1);
        push_step(2);
        push_line(3, 0, 0, 3);
        push_step(4);
        // zero length line gives no pixels
        push_line(5, 5, 5, 5);
        push_step(1);
        // steep rising line
        push_line(0, 0, 1, 3);
        push_step(3);
        // full-range diagonals, outside the canvas
        push_line(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
        push_step(2);
        push_line(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
        push_step(1);
        // shallow falling line
        push_line(0, 2, 6, 0);
        push_step(2);
        wait_idle();

        for (int s = 0; s < 6; s++)
        begin
            case (s / 2)
                0:       begin send_idle_pct = 20; recv_idle_pct = 77; end
                1:       begin send_idle_pct = 77; recv_idle_pct = 20; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            value = (clip_plan[s] < 0) ? int'($urandom_range(4096, 1)) : clip_plan[s];
            program_clip(value);
            queue_random_lines(110);
            // pause the sender until all pixels have drained
            wait_idle();
            queue_random_lines(110);
            wait_idle();
        end

        if (bad_count == 0)
            $display("PASS bresenham_line_rasterizer_core");
        else
            $display("FAIL bresenham_line_rasterizer_core");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL bresenham_line_rasterizer_core");
        $finish;
    end

endmodule

### sim.f
hdl/brl_pkg.sv
hdl/brl_front.sv
hdl/brl_queue.sv
hdl/brl_back.sv
hdl/bresenham_line_rasterizer_core.sv
tb/tb_bresenham_line_rasterizer_core.sv
